### hdl/iif_pkg.sv
package iif_pkg;

   // default filter order (forward taps; backward taps are one fewer)
   localparam int ORDER_DEF = 8;

   localparam int DATA_W   = 32;
   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 16;
   localparam int INDEX_W  = 3;
   localparam int KIND_W   = 2;

   // request packing: sample, coef_index, coef_value, padded to whole bytes
   localparam int REQ_FIELDS_W = SAMPLE_W + INDEX_W + COEF_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;

   typedef enum logic [KIND_W-1:0] {
      KIND_SAMPLE   = 2'd0,
      KIND_FWD_COEF = 2'd1,
      KIND_BWD_COEF = 2'd2,
      KIND_FILL     = 2'd3
   } kind_type;

   // tap descriptor that travels alongside the memory read data
   typedef struct packed {
      logic vld;
      logic back;
      logic first;
      logic last;
      logic hv;
      logic cv;
   } mac_ctl_type;

endpackage

### hdl/iif_ram.sv
module iif_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/iif_mac.sv
module iif_mac (
   input  logic                clock,
   input  logic                reset,
   input  iif_pkg::mac_ctl_type ctl,
   input  logic [31:0]         hist_rdata,
   input  logic [15:0]         coef_rdata,
   input  logic [15:0]         fill_value,
   output logic [31:0]         acc,
   output logic                done
);
   import iif_pkg::*;

   logic [DATA_W-1:0]          hist_op;
   logic [COEF_W-1:0]          coef_op;
   logic [DATA_W+COEF_W-1:0]   prod_full;
   logic [DATA_W-1:0]          prod_ff;
   mac_ctl_type                s1_ff;
   logic [DATA_W-1:0]          acc_ff;
   logic [DATA_W-1:0]          acc_base;
   logic [DATA_W-1:0]          acc_in;
   logic                       done_ff;

   // entries never written since the last fill read as the fill value,
   // coefficients never written read as zero
   always_comb begin
      hist_op   = ctl.hv ? hist_rdata
                         : {{(DATA_W-SAMPLE_W){fill_value[SAMPLE_W-1]}}, fill_value};
      coef_op   = ctl.cv ? coef_rdata : '0;
      prod_full = $signed(hist_op) * $signed(coef_op);
   end

   // wrapping accumulate, backward taps subtract
   always_comb begin
      acc_base = s1_ff.first ? '0 : acc_ff;
      acc_in   = s1_ff.back ? (acc_base - prod_ff) : (acc_base + prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff   <= '0;
         done_ff <= 1'b0;
      end else begin
         s1_ff   <= ctl;
         done_ff <= s1_ff.vld && s1_ff.last;
      end
      prod_ff <= prod_full[DATA_W-1:0];
      if (s1_ff.vld) begin
         acc_ff <= acc_in;
      end
   end

   assign acc  = acc_ff;
   assign done = done_ff;

endmodule

### hdl/iif_ctrl.sv
module iif_ctrl #(
   parameter int ORDER = iif_pkg::ORDER_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  iif_pkg::kind_type              req_kind,
   input  logic [15:0]                    req_sample,
   input  logic [2:0]                     req_coef_index,
   input  logic [15:0]                    req_coef_value,
   input  logic [15:0]                    start_value,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [31:0]                    rsp_tdata,
   output logic                           hist_we,
   output logic [$clog2(2*ORDER-1)-1:0]   hist_waddr,
   output logic [31:0]                    hist_wdata,
   output logic [$clog2(2*ORDER-1)-1:0]   hist_raddr,
   output logic                           coef_we,
   output logic [$clog2(2*ORDER-1)-1:0]   coef_waddr,
   output logic [15:0]                    coef_wdata,
   output logic [$clog2(2*ORDER-1)-1:0]   coef_raddr,
   output iif_pkg::mac_ctl_type           mac_ctl,
   output logic [15:0]                    fill_value,
   input  logic                           mac_done,
   input  logic [31:0]                    mac_acc
);
   import iif_pkg::*;

   localparam int NTAP = 2*ORDER - 1;
   localparam int AW   = $clog2(NTAP);
   localparam int PW   = $clog2(ORDER);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_TAPS  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   function automatic logic [PW-1:0] adv_pos(input logic [PW-1:0] p, input int n);
      if (int'(p) + 1 >= n) begin
         return '0;
      end
      return p + PW'(1);
   endfunction

   state_type          state_ff, state_in;
   logic [AW-1:0]      tap_ff, tap_in;
   logic [PW-1:0]      xpos_ff, xpos_in;
   logic [PW-1:0]      ypos_ff, ypos_in;
   logic [PW-1:0]      rx_ff, rx_in;
   logic [PW-1:0]      ry_ff, ry_in;
   logic [NTAP-1:0]    hist_vld_ff, hist_vld_in;
   logic [NTAP-1:0]    coef_vld_ff, coef_vld_in;
   logic [SAMPLE_W-1:0] fill_ff, fill_in;
   mac_ctl_type        ctl_ff, ctl_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [DATA_W-1:0]  rsp_tdata_ff, rsp_tdata_in;

   logic               accept;
   logic               is_back;
   logic               last_tap;
   logic               out_free;
   logic               finish;
   logic [PW-1:0]      new_x;
   logic [PW-1:0]      y_slot;
   logic               fwd_ok;
   logic               bwd_ok;

   always_comb begin
      accept   = req_tvalid && (state_ff == ST_IDLE);
      is_back  = int'(tap_ff) >= ORDER;
      last_tap = int'(tap_ff) == NTAP - 1;
      out_free = !rsp_tvalid_ff || rsp_tready;
      finish   = (state_ff == ST_DONE) && out_free;
      new_x    = adv_pos(xpos_ff, ORDER);
      y_slot   = adv_pos(ypos_ff, ORDER - 1);
      fwd_ok   = int'(req_coef_index) < ORDER;
      bwd_ok   = int'(req_coef_index) < ORDER - 1;
   end

   // read side: forward taps walk the input ring, backward taps the output ring
   always_comb begin
      hist_raddr = is_back ? (AW'(ORDER) + AW'(ry_ff)) : AW'(rx_ff);
      coef_raddr = tap_ff;
      ctl_in.vld   = (state_ff == ST_TAPS);
      ctl_in.back  = is_back;
      ctl_in.first = (tap_ff == '0);
      ctl_in.last  = last_tap;
      ctl_in.hv    = hist_vld_ff[hist_raddr];
      ctl_in.cv    = coef_vld_ff[coef_raddr];
   end

   // write side: new sample or coefficient on accept, new output on finish
   always_comb begin
      hist_we    = 1'b0;
      hist_waddr = AW'(new_x);
      hist_wdata = {{(DATA_W-SAMPLE_W){req_sample[SAMPLE_W-1]}}, req_sample};
      if (accept && (req_kind == KIND_SAMPLE)) begin
         hist_we = 1'b1;
      end else if (finish) begin
         hist_we    = 1'b1;
         hist_waddr = AW'(ORDER) + AW'(y_slot);
         hist_wdata = mac_acc;
      end
      coef_we    = 1'b0;
      coef_waddr = AW'(req_coef_index);
      coef_wdata = req_coef_value;
      if (accept && (req_kind == KIND_FWD_COEF) && fwd_ok) begin
         coef_we = 1'b1;
      end else if (accept && (req_kind == KIND_BWD_COEF) && bwd_ok) begin
         coef_we    = 1'b1;
         coef_waddr = AW'(ORDER) + AW'(req_coef_index);
      end
   end

   always_comb begin
      state_in      = state_ff;
      tap_in        = tap_ff;
      xpos_in       = xpos_ff;
      ypos_in       = ypos_ff;
      rx_in         = rx_ff;
      ry_in         = ry_ff;
      hist_vld_in   = hist_vld_ff;
      coef_vld_in   = coef_vld_ff;
      fill_in       = fill_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;

      if (hist_we) begin
         hist_vld_in[hist_waddr] = 1'b1;
      end
      if (coef_we) begin
         coef_vld_in[coef_waddr] = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_SAMPLE: begin
                     xpos_in  = new_x;
                     rx_in    = adv_pos(new_x, ORDER);
                     ry_in    = y_slot;
                     tap_in   = '0;
                     state_in = ST_TAPS;
                  end
                  KIND_FILL: begin
                     hist_vld_in = '0;
                     fill_in     = start_value;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_TAPS: begin
            if (is_back) begin
               ry_in = adv_pos(ry_ff, ORDER - 1);
            end else begin
               rx_in = adv_pos(rx_ff, ORDER);
            end
            // tap counter rests on the last tap so reads stay inside the tables
            if (last_tap) begin
               state_in = ST_DRAIN;
            end else begin
               tap_in = tap_ff + AW'(1);
            end
         end
         ST_DRAIN: begin
            if (mac_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (finish) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = mac_acc;
               ypos_in       = y_slot;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tap_ff        <= '0;
         xpos_ff       <= PW'(ORDER - 1);
         ypos_ff       <= PW'(ORDER - 2);
         rx_ff         <= '0;
         ry_ff         <= '0;
         hist_vld_ff   <= '0;
         coef_vld_ff   <= '0;
         fill_ff       <= '0;
         ctl_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tap_ff        <= tap_in;
         xpos_ff       <= xpos_in;
         ypos_ff       <= ypos_in;
         rx_ff         <= rx_in;
         ry_ff         <= ry_in;
         hist_vld_ff   <= hist_vld_in;
         coef_vld_ff   <= coef_vld_in;
         fill_ff       <= fill_in;
         ctl_ff        <= ctl_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign mac_ctl    = ctl_ff;
   assign fill_value = fill_ff;

endmodule

### hdl/integer_iir_filter_top.sv
// integer direct-form-I iir filter. a request of kind sample pushes the sample into an
// ORDER-deep input ring, forms the sum of forward coefficients times inputs (oldest first,
// the last coefficient weighting the newest sample), subtracts the sum of ORDER-1 backward
// coefficients times past outputs, returns the difference on rsp and pushes it into the
// output ring; all arithmetic wraps modulo 2^32. kinds 1 and 2 load one forward or
// backward coefficient (an index beyond the table is dropped), kind 3 sets both histories
// to the start_value register; these give no response. a sample is computed by the single
// multiply-accumulate unit that steps through all 2*ORDER-1 taps, one read of the history
// and coefficient memories per tap. a new request is taken as soon as the result sits in
// the output register, even if it has not yet been collected. start_value may be written
// on csr at any cycle while no sample is in progress.
module integer_iir_filter_top #(
   parameter int ORDER = iif_pkg::ORDER_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // sample[15:0], coef_index[18:16], coef_value[34:19]
   input  logic [1:0]  req_tuser,   // kind[1:0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // filtered[31:0]
   // start_value register
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic [15:0] csr_tdata    // start_value[15:0]
);
   import iif_pkg::*;

   localparam int NTAP = 2*ORDER - 1;
   localparam int AW   = $clog2(NTAP);

   logic [SAMPLE_W-1:0] start_value_ff, start_value_in;

   kind_type            req_kind;
   logic [SAMPLE_W-1:0] req_sample;
   logic [INDEX_W-1:0]  req_coef_index;
   logic [COEF_W-1:0]   req_coef_value;

   logic                hist_we;
   logic [AW-1:0]       hist_waddr;
   logic [DATA_W-1:0]   hist_wdata;
   logic [AW-1:0]       hist_raddr;
   logic [DATA_W-1:0]   hist_rdata;
   logic                coef_we;
   logic [AW-1:0]       coef_waddr;
   logic [COEF_W-1:0]   coef_wdata;
   logic [AW-1:0]       coef_raddr;
   logic [COEF_W-1:0]   coef_rdata;

   mac_ctl_type         mac_ctl;
   logic [SAMPLE_W-1:0] fill_value;
   logic                mac_done;
   logic [DATA_W-1:0]   mac_acc;

   // request unpacking
   always_comb begin
      req_kind       = kind_type'(req_tuser);
      req_sample     = req_tdata[SAMPLE_W-1:0];
      req_coef_index = req_tdata[SAMPLE_W+INDEX_W-1:SAMPLE_W];
      req_coef_value = req_tdata[REQ_FIELDS_W-1:SAMPLE_W+INDEX_W];
   end

   // start_value register, always writable
   assign csr_tready     = 1'b1;
   assign start_value_in = (csr_tvalid && csr_tready) ? csr_tdata : start_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_value_ff <= '0;
      end else begin
         start_value_ff <= start_value_in;
      end
   end

   // sequencer: ring pointers, tap walk, valid bits and response register
   iif_ctrl #(.ORDER(ORDER)) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_kind       (req_kind),
      .req_sample     (req_sample),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .start_value    (start_value_ff),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .hist_we        (hist_we),
      .hist_waddr     (hist_waddr),
      .hist_wdata     (hist_wdata),
      .hist_raddr     (hist_raddr),
      .coef_we        (coef_we),
      .coef_waddr     (coef_waddr),
      .coef_wdata     (coef_wdata),
      .coef_raddr     (coef_raddr),
      .mac_ctl        (mac_ctl),
      .fill_value     (fill_value),
      .mac_done       (mac_done),
      .mac_acc        (mac_acc)
   );

   // input ring in the lower ORDER entries, output ring above it
   iif_ram #(.WIDTH(DATA_W), .DEPTH(NTAP)) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hist_waddr),
      .wr_data (hist_wdata),
      .rd_addr (hist_raddr),
      .rd_data (hist_rdata)
   );

   // forward coefficients in the lower ORDER entries, backward ones above
   iif_ram #(.WIDTH(COEF_W), .DEPTH(NTAP)) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr (coef_waddr),
      .wr_data (coef_wdata),
      .rd_addr (coef_raddr),
      .rd_data (coef_rdata)
   );

   // shared multiply-accumulate, two stages behind the memory read
   iif_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .ctl        (mac_ctl),
      .hist_rdata (hist_rdata),
      .coef_rdata (coef_rdata),
      .fill_value (fill_value),
      .acc        (mac_acc),
      .done       (mac_done)
   );

   // a sample request closes the request side for the computation
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == KIND_SAMPLE)) |=> !req_tready)
      else $error("request side open right after a sample request");

   // the accumulator only completes while a sample is in progress
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> !req_tready)
      else $error("accumulation finished while idle");

   // a response only appears at the end of a computation
   a_rsp_after_calc: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("response raised without a computation");

endmodule
